// ----- hw/rtl/per_class_bounded_queue_assert.svh -----
// Assertion helpers for the per-class bounded queue.
`ifndef PER_CLASS_BOUNDED_QUEUE_ASSERT_SVH
`define PER_CLASS_BOUNDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PCBQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcbq: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define PCBQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcbq: next-cycle check failed");

`endif

// ----- hw/rtl/pcbq_pkg.sv -----
`timescale 1ns / 1ps

package pcbq_pkg;

   // Defaults for the top-level parameters
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int NUM_TOPICS_DEF  = 4;

   // Register map
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] CSR_CAP0 = 3'd0;
   localparam logic [2:0] CSR_CAP1 = 3'd1;
   localparam logic [2:0] CSR_CAP2 = 3'd2;
   localparam logic [2:0] CSR_CAP3 = 3'd3;
   localparam logic [2:0] CSR_MASK = 3'd4;
   localparam logic [4:0] CAP_RESET = 5'd4;

   // Request operations
   localparam logic [2:0] OP_ENQUEUE = 3'd0;
   localparam logic [2:0] OP_DEQUEUE = 3'd1;
   localparam logic [2:0] OP_PAUSE   = 3'd2;
   localparam logic [2:0] OP_STOP    = 3'd3;
   localparam logic [2:0] OP_FLUSH   = 3'd4;

   // Response status codes
   localparam logic [2:0] ST_ACCEPTED      = 3'd0;
   localparam logic [2:0] ST_ACCEPTED_DROP = 3'd1;
   localparam logic [2:0] ST_REJECTED      = 3'd2;
   localparam logic [2:0] ST_DELIVERED     = 3'd3;
   localparam logic [2:0] ST_NOTHING       = 3'd4;
   localparam logic [2:0] ST_FINISHED      = 3'd5;
   localparam logic [2:0] ST_DONE          = 3'd6;

   typedef struct packed {
      logic [2:0]  operation;
      logic [1:0]  topic;
      logic [3:0]  sender;
      logic [31:0] payload_handle;
      logic        flag;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  out_topic;
      logic [3:0]  out_sender;
      logic [31:0] out_payload;
      logic [4:0]  waiting_count;
      logic [31:0] rejected_count;
      logic [31:0] dropped_count;
      logic [31:0] delivered_count;
   } rsp_type;

   // One queued entry as held by a cell
   typedef struct packed {
      logic [1:0]  topic;
      logic [3:0]  sender;
      logic [31:0] payload;
   } entry_type;

   // Broadcast to every cell of the row
   typedef struct packed {
      logic       remove;
      logic       match_en;
      logic [1:0] topic;
   } cell_cmd_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [3:0][4:0] capacity;
      logic [3:0]      latest_mask;
   } cfg_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] value);
      logic [31:0] result;
      result = (value == '1) ? value : value + 32'd1;
      return result;
   endfunction

endpackage

// ----- hw/rtl/pcbq_cell.sv -----
`timescale 1ns / 1ps

// One slot of the queue row: holds an entry, flags a topic match, and
// takes its neighbour's entry when the removal front has reached it.
module pcbq_cell (
   input  logic                  clock,
   input  pcbq_pkg::cell_cmd_type cmd,
   input  logic                  occupied,
   input  logic                  load_sel,
   input  logic                  seen_in,
   output logic                  seen_out,
   input  pcbq_pkg::entry_type   next_entry,
   input  pcbq_pkg::entry_type   new_entry,
   output pcbq_pkg::entry_type   entry
);
   import pcbq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      hit;
   logic      shift;

   // first same-topic entry starts the removal front
   assign hit      = cmd.match_en & occupied & (entry_ff.topic == cmd.topic);
   assign seen_out = seen_in | hit;
   assign shift    = cmd.remove & seen_out;

   // a new entry wins over the shift
   always_comb begin
      entry_in = entry_ff;
      if (shift) begin
         entry_in = next_entry;
      end
      if (load_sel) begin
         entry_in = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- hw/rtl/pcbq_csr.sv -----
`timescale 1ns / 1ps

// Configuration registers behind the APB-style port.
module pcbq_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pcbq_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output pcbq_pkg::cfg_type               cfg
);
   import pcbq_pkg::*;

   cfg_type    cfg_ff;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity    <= {4{CAP_RESET}};
         cfg_ff.latest_mask <= '0;
      end else if (wr_en) begin
         unique case (reg_idx) inside
            CSR_CAP0, CSR_CAP1, CSR_CAP2, CSR_CAP3: begin
               cfg_ff.capacity[reg_idx[1:0]] <= pwdata[4:0];
            end
            CSR_MASK: begin
               cfg_ff.latest_mask <= pwdata[3:0];
            end
            default: begin
            end
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (reg_idx) inside
         CSR_CAP0, CSR_CAP1, CSR_CAP2, CSR_CAP3: begin
            prdata = 32'(cfg_ff.capacity[reg_idx[1:0]]);
         end
         CSR_MASK: begin
            prdata = 32'(cfg_ff.latest_mask);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/per_class_bounded_queue.sv -----
`timescale 1ns / 1ps

// Shared FIFO of topic-tagged entries with a per-topic capacity limit.
// Requests: drive req_data and raise start; a request is taken at a clock
// edge where start is high and busy is low. busy stays high for one cycle.
// Each request gives exactly one response: rsp_valid is high for the cycle
// after the busy cycle, and the response is taken at the clock edge that
// ends it. A new request may be taken at that same edge. The busy cycle
// evaluates the topic match chain in the row of entry cells and shifts the
// row to close a removed slot.
// The receiver cannot stall; every response must be taken when shown.
// Configuration goes through the APB-style port (psel, penable, pwrite,
// paddr, pwdata, prdata, pready), zero wait states; the user must write it
// only while idle, and the block itself does not enforce this.
// Register map: capacity of topics 0..3 at 0x0..0xC, latest-value mask
// at 0x10.
// Reset (synchronous): queue empty, input open, delivery paused, counters
// cleared, capacities 4, every topic reliable. No clearing pass is needed.
module per_class_bounded_queue #(
   parameter int QUEUE_DEPTH = pcbq_pkg::QUEUE_DEPTH_DEF,
   parameter int NUM_TOPICS  = pcbq_pkg::NUM_TOPICS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  pcbq_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output pcbq_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pcbq_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import pcbq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   cfg_type cfg;

   // control state
   logic             busy_ff;
   logic             rsp_valid_ff;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [CNT_W-1:0] tcount_ff [NUM_TOPICS];
   logic [CNT_W-1:0] tcount_in [NUM_TOPICS];
   logic             accepting_ff, accepting_in;
   logic             paused_ff,    paused_in;
   logic             stopping_ff,  stopping_in;
   logic [31:0]      rejected_ff,  rejected_in;
   logic [31:0]      dropped_ff,   dropped_in;
   logic [31:0]      delivered_ff, delivered_in;

   // payload registers
   req_type          req_ff;
   rsp_type          rsp_ff,  rsp_in;

   // datapath signals
   logic             accept;
   logic             topic_ok;
   logic [CNT_W-1:0] same;
   logic [4:0]       cap;
   logic             topic_full;
   logic             topic_latest;
   logic             drop;
   logic             deliver;
   logic             do_load;
   logic [CNT_W-1:0] wr_idx;
   logic [32:0]      drop_sum;
   cell_cmd_type     cmd;
   entry_type        new_entry;
   entry_type        entries [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0]   seen;
   logic [QUEUE_DEPTH-1:0] occupied;
   logic [QUEUE_DEPTH-1:0] load_sel;

   pcbq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign accept = start & ~busy_ff;

   // topic lookup
   assign topic_ok     = ({1'b0, req_ff.topic} < 3'(NUM_TOPICS));
   assign cap          = cfg.capacity[req_ff.topic];
   assign topic_latest = cfg.latest_mask[req_ff.topic];
   assign topic_full   = (CMP_W'(same) >= CMP_W'(cap));

   always_comb begin
      same = '0;
      for (int t = 0; t < NUM_TOPICS; t++) begin
         if (req_ff.topic == 2'(t)) begin
            same = tcount_ff[t];
         end
      end
   end

   assign drop_sum = {1'b0, dropped_ff} + 33'(count_ff);

   // request evaluation, in the busy cycle of every request
   always_comb begin
      count_in     = count_ff;
      tcount_in    = tcount_ff;
      accepting_in = accepting_ff;
      paused_in    = paused_ff;
      stopping_in  = stopping_ff;
      rejected_in  = rejected_ff;
      dropped_in   = dropped_ff;
      delivered_in = delivered_ff;
      drop         = 1'b0;
      deliver      = 1'b0;
      do_load      = 1'b0;
      wr_idx       = count_ff;
      rsp_in        = '0;
      rsp_in.status = ST_DONE;

      if (busy_ff) begin
         unique case (req_ff.operation)
            OP_ENQUEUE: begin
               if (!accepting_ff || !topic_ok) begin
                  rsp_in.status = ST_REJECTED;
                  rejected_in   = sat_inc(rejected_ff);
               end else if (topic_full && !topic_latest) begin
                  rsp_in.status = ST_REJECTED;
                  rejected_in   = sat_inc(rejected_ff);
               end else if (topic_full && same != '0) begin
                  // latest-value: drop own oldest, append at the freed end
                  drop          = 1'b1;
                  do_load       = 1'b1;
                  wr_idx        = count_ff - 1'b1;
                  rsp_in.status = ST_ACCEPTED_DROP;
                  dropped_in    = sat_inc(dropped_ff);
               end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  rsp_in.status = ST_REJECTED;
                  rejected_in   = sat_inc(rejected_ff);
               end else begin
                  do_load       = 1'b1;
                  count_in      = count_ff + 1'b1;
                  rsp_in.status = ST_ACCEPTED;
                  for (int t = 0; t < NUM_TOPICS; t++) begin
                     if (req_ff.topic == 2'(t)) begin
                        tcount_in[t] = tcount_ff[t] + 1'b1;
                     end
                  end
               end
            end
            OP_DEQUEUE: begin
               if (count_ff == '0 && stopping_ff) begin
                  rsp_in.status = ST_FINISHED;
               end else if (paused_ff || count_ff == '0) begin
                  rsp_in.status = ST_NOTHING;
               end else begin
                  deliver            = 1'b1;
                  count_in           = count_ff - 1'b1;
                  delivered_in       = sat_inc(delivered_ff);
                  rsp_in.status      = ST_DELIVERED;
                  rsp_in.out_topic   = entries[0].topic;
                  rsp_in.out_sender  = entries[0].sender;
                  rsp_in.out_payload = entries[0].payload;
                  for (int t = 0; t < NUM_TOPICS; t++) begin
                     if (entries[0].topic == 2'(t)) begin
                        tcount_in[t] = tcount_ff[t] - 1'b1;
                     end
                  end
               end
            end
            OP_PAUSE: begin
               paused_in = req_ff.flag;
            end
            OP_STOP: begin
               accepting_in = 1'b0;
               paused_in    = 1'b0;
               stopping_in  = 1'b1;
               if (req_ff.flag) begin
                  dropped_in = drop_sum[32] ? '1 : drop_sum[31:0];
                  count_in   = '0;
                  for (int t = 0; t < NUM_TOPICS; t++) begin
                     tcount_in[t] = '0;
                  end
               end
            end
            OP_FLUSH: begin
               dropped_in = drop_sum[32] ? '1 : drop_sum[31:0];
               count_in   = '0;
               for (int t = 0; t < NUM_TOPICS; t++) begin
                  tcount_in[t] = '0;
               end
            end
            default: begin
            end
         endcase
      end

      rsp_in.waiting_count   = 5'(count_in);
      rsp_in.rejected_count  = rejected_in;
      rsp_in.dropped_count   = dropped_in;
      rsp_in.delivered_count = delivered_in;
   end

   // command broadcast to the row
   assign cmd.remove   = drop | deliver;
   assign cmd.match_en = drop;
   assign cmd.topic    = req_ff.topic;

   assign new_entry.topic   = req_ff.topic;
   assign new_entry.sender  = req_ff.sender;
   assign new_entry.payload = req_ff.payload_handle;

   // dequeue seeds the removal front at the head
   assign seen[0] = deliver;

   // row of entry cells, head at index 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type next_entry;

      assign occupied[i] = (CNT_W'(i) < count_ff);
      assign load_sel[i] = do_load & (wr_idx == CNT_W'(i));

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_entry = entries[i];
      end else begin : g_body
         assign next_entry = entries[i + 1];
      end

      pcbq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (occupied[i]),
         .load_sel   (load_sel[i]),
         .seen_in    (seen[i]),
         .seen_out   (seen[i + 1]),
         .next_entry (next_entry),
         .new_entry  (new_entry),
         .entry      (entries[i])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         for (int t = 0; t < NUM_TOPICS; t++) begin
            tcount_ff[t] <= '0;
         end
         accepting_ff <= 1'b1;
         paused_ff    <= 1'b1;
         stopping_ff  <= 1'b0;
         rejected_ff  <= '0;
         dropped_ff   <= '0;
         delivered_ff <= '0;
      end else begin
         busy_ff      <= accept;
         rsp_valid_ff <= busy_ff;
         count_ff     <= count_in;
         tcount_ff    <= tcount_in;
         accepting_ff <= accepting_in;
         paused_ff    <= paused_in;
         stopping_ff  <= stopping_in;
         rejected_ff  <= rejected_in;
         dropped_ff   <= dropped_in;
         delivered_ff <= delivered_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (busy_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "per_class_bounded_queue_assert.svh"

   `PCBQ_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy_ff)
   `PCBQ_ASSERT_NEXT(a_busy_rsp, clock, reset, busy_ff, rsp_valid_ff && !busy_ff)
   `PCBQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `PCBQ_ASSERT_SAME(a_quiet_fields, clock, reset,
      rsp_valid_ff && rsp_ff.status != ST_DELIVERED,
      {rsp_ff.out_topic, rsp_ff.out_sender, rsp_ff.out_payload} == '0)

endmodule

// ----- verif/per_class_bounded_queue_tb.sv -----
`timescale 1ns / 1ps

module per_class_bounded_queue_tb;
   import pcbq_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEF;
   localparam int N_TOPICS = NUM_TOPICS_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;
   // Operation codes with no meaning: the block answers "done"
   localparam logic [2:0] OP_RESERVED_LO = 3'd5;
   localparam logic [2:0] OP_RESERVED_HI = 3'd7;
   localparam logic [31:0] COUNT_MAX = '1;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   per_class_bounded_queue DUT (.*);

   always #5 clock = ~clock;

   // Shadow copy of the queue, its flags, counters and registers
   entry_type shadow_entry [DEPTH];
   int shadow_count;
   logic shadow_open;
   logic shadow_paused;
   logic shadow_stopping;
   logic [31:0] shadow_rejected;
   logic [31:0] shadow_dropped;
   logic [31:0] shadow_delivered;
   logic [4:0] shadow_cap [4];
   logic [3:0] shadow_latest;

   rsp_type awaited_responses[$];
   int mismatch_count = 0;
   int gap_pct = 16;
   int idle_cycles = 0;

   function automatic logic [31:0] saturating_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? COUNT_MAX : sum[31:0];
   endfunction

   function automatic void reset_shadow();
      shadow_count = 0;
      shadow_open = 1'b1;
      shadow_paused = 1'b1;
      shadow_stopping = 1'b0;
      shadow_rejected = '0;
      shadow_dropped = '0;
      shadow_delivered = '0;
      for (int t = 0; t < 4; t++) shadow_cap[t] = CAP_RESET;
      shadow_latest = '0;
   endfunction

   // Remove one slot and close the gap, keeping the order of the rest
   function automatic void close_slot(int pos);
      int i;
      for (i = pos; i < shadow_count - 1; i++) shadow_entry[i] = shadow_entry[i + 1];
      if (shadow_count > 0) shadow_count--;
   endfunction

   function automatic void discard_pending();
      shadow_dropped = saturating_add(shadow_dropped, shadow_count);
      shadow_count = 0;
   endfunction

   // Enqueue: closed input, per-topic limit with reject or drop-oldest, depth bound
   function automatic logic [2:0] admit_entry(req_type r);
      int i;
      int same;
      int oldest;
      logic found;
      logic refused;
      logic [2:0] status;
      same = 0;
      oldest = 0;
      found = 1'b0;
      refused = 1'b0;
      status = ST_ACCEPTED;
      if (!shadow_open || r.topic >= N_TOPICS) begin
         refused = 1'b1;
      end else begin
         for (i = 0; i < shadow_count; i++) begin
            if (shadow_entry[i].topic == r.topic) begin
               if (!found) begin
                  oldest = i;
                  found = 1'b1;
               end
               same++;
            end
         end
         if (same >= shadow_cap[r.topic]) begin
            if (!shadow_latest[r.topic]) begin
               refused = 1'b1;
            end else if (found) begin
               close_slot(oldest);
               shadow_dropped = saturating_add(shadow_dropped, 1);
               status = ST_ACCEPTED_DROP;
            end
         end
         if (!refused && shadow_count >= DEPTH) refused = 1'b1;
      end
      if (refused) begin
         shadow_rejected = saturating_add(shadow_rejected, 1);
         status = ST_REJECTED;
      end else begin
         shadow_entry[shadow_count] = '{topic: r.topic, sender: r.sender,
                                        payload: r.payload_handle};
         shadow_count++;
      end
      return status;
   endfunction

   function automatic rsp_type compute_queue_response(req_type r);
      rsp_type o;
      o = '0;
      o.status = ST_DONE;
      case (r.operation)
         OP_ENQUEUE: o.status = admit_entry(r);
         OP_DEQUEUE: begin
            if (shadow_count == 0 && shadow_stopping) begin
               o.status = ST_FINISHED;
            end else if (shadow_paused || shadow_count == 0) begin
               o.status = ST_NOTHING;
            end else begin
               o.out_topic = shadow_entry[0].topic;
               o.out_sender = shadow_entry[0].sender;
               o.out_payload = shadow_entry[0].payload;
               close_slot(0);
               shadow_delivered = saturating_add(shadow_delivered, 1);
               o.status = ST_DELIVERED;
            end
         end
         OP_PAUSE: shadow_paused = r.flag;
         OP_STOP: begin
            shadow_open = 1'b0;
            shadow_paused = 1'b0;
            shadow_stopping = 1'b1;
            if (r.flag) discard_pending();
         end
         OP_FLUSH: discard_pending();
         default: ;
      endcase
      o.waiting_count = 5'(shadow_count);
      o.rejected_count = shadow_rejected;
      o.dropped_count = shadow_dropped;
      o.delivered_count = shadow_delivered;
      return o;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // Response checker: every strobed response against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none, actual %0h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            want = awaited_responses.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("out_topic", want.out_topic, rsp_data.out_topic);
            check_field("out_sender", want.out_sender, rsp_data.out_sender);
            check_field("out_payload", want.out_payload, rsp_data.out_payload);
            check_field("waiting_count", want.waiting_count, rsp_data.waiting_count);
            check_field("rejected_count", want.rejected_count, rsp_data.rejected_count);
            check_field("dropped_count", want.dropped_count, rsp_data.dropped_count);
            check_field("delivered_count", want.delivered_count, rsp_data.delivered_count);
         end
      end
   end

   // Watchdog: cycles with neither a request taken nor a response shown
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // One request: optional idle gap, then hold start until the block takes it
   task automatic send_request(input req_type r);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      awaited_responses.push_back(compute_queue_response(r));
   endtask

   task automatic issue(input logic [2:0] op, input logic [1:0] topic,
                        input logic [3:0] sender, input logic [31:0] payload,
                        input logic flag);
      req_type r;
      r.operation = op;
      r.topic = topic;
      r.sender = sender;
      r.payload_handle = payload;
      r.flag = flag;
      send_request(r);
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup then access phase
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [4:0] c0, input logic [4:0] c1,
                                 input logic [4:0] c2, input logic [4:0] c3,
                                 input logic [3:0] mask);
      wait_quiet();
      csr_write(CSR_CAP0, c0);
      csr_write(CSR_CAP1, c1);
      csr_write(CSR_CAP2, c2);
      csr_write(CSR_CAP3, c3);
      csr_write(CSR_MASK, mask);
      shadow_cap[0] = c0;
      shadow_cap[1] = c1;
      shadow_cap[2] = c2;
      shadow_cap[3] = c3;
      shadow_latest = mask;
   endtask

   // Random request; half the enqueues aim at one topic to hit its limit
   function automatic req_type random_request(int enq_pct, int deq_pct,
                                              logic [1:0] hot, bit allow_stop);
      req_type r;
      int roll;
      int pick;
      r.topic = ($urandom_range(1) == 0) ? hot : 2'($urandom_range(3));
      r.sender = 4'($urandom_range(15));
      r.payload_handle = $urandom;
      r.flag = 1'($urandom_range(1));
      roll = $urandom_range(99);
      pick = $urandom_range(9);
      if (roll < enq_pct) begin
         r.operation = OP_ENQUEUE;
      end else if (roll < enq_pct + deq_pct) begin
         r.operation = OP_DEQUEUE;
      end else if (pick < 6) begin
         // mostly release delivery so dequeues get somewhere
         r.operation = OP_PAUSE;
         r.flag = ($urandom_range(4) == 0);
      end else if (pick < 8) begin
         r.operation = OP_FLUSH;
      end else if (pick == 8 && allow_stop) begin
         r.operation = OP_STOP;
      end else begin
         r.operation = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
      end
      return r;
   endfunction

   task automatic random_phase(input int count, input int enq_pct, input int deq_pct,
                               input logic [1:0] hot, input bit allow_stop);
      for (int n = 0; n < count; n++)
         send_request(random_request(enq_pct, deq_pct, hot, allow_stop));
   endtask

   // Empty and paused after reset; reserved codes answer done
   task automatic test_idle_answers();
      issue(OP_DEQUEUE, 2'd0, 4'd0, 32'd0, 1'b0);
      for (int k = 0; k < 3; k++) issue(OP_RESERVED_LO + 3'(k), 2'd3, 4'hF, '1, 1'b1);
   endtask

   task automatic test_field_extremes();
      issue(OP_ENQUEUE, 2'd0, 4'h0, 32'h0000_0000, 1'b0);
      issue(OP_ENQUEUE, 2'd3, 4'hF, 32'hFFFF_FFFF, 1'b1);
      issue(OP_PAUSE, 2'd0, 4'h0, 32'd0, 1'b0);
      issue(OP_DEQUEUE, 2'd0, 4'h0, 32'd0, 1'b0);
      issue(OP_DEQUEUE, 2'd0, 4'h0, 32'd0, 1'b0);
   endtask

   // Reset capacity on a reliable topic: fifth request rejected
   task automatic test_reliable_limit();
      for (int k = 0; k < 5; k++) issue(OP_ENQUEUE, 2'd1, 4'(k), $urandom, 1'b0);
      issue(OP_FLUSH, 2'd0, 4'd0, 32'd0, 1'b0);
   endtask

   // Latest-value topic drops its own oldest; zero capacity latest accepts
   task automatic test_latest_drop();
      apply_settings(5'd1, 5'd2, 5'd0, 5'd31, 4'b0110);
      issue(OP_ENQUEUE, 2'd1, 4'd1, 32'hA000_0001, 1'b0);
      issue(OP_ENQUEUE, 2'd0, 4'd2, 32'hB000_0002, 1'b0);
      issue(OP_ENQUEUE, 2'd1, 4'd3, 32'hC000_0003, 1'b0);
      issue(OP_ENQUEUE, 2'd1, 4'd4, 32'hD000_0004, 1'b0);
      issue(OP_ENQUEUE, 2'd2, 4'd5, 32'hE000_0005, 1'b0);
      issue(OP_PAUSE, 2'd0, 4'd0, 32'd0, 1'b1);
      issue(OP_DEQUEUE, 2'd0, 4'd0, 32'd0, 1'b0);
   endtask

   task automatic test_random_mix();
      logic [4:0] caps [4];
      apply_settings(5'd2, 5'd3, 5'd1, 5'd5, 4'b0101);
      random_phase(100, 55, 35, 2'd2, 1'b0);
      // long stretch with no gaps; fills up to the depth bound
      gap_pct = 0;
      apply_settings(5'd31, 5'd31, 5'd31, 5'd31, 4'b0000);
      random_phase(100, 70, 20, 2'd3, 1'b0);
      gap_pct = 16;
      // zero-capacity reliable topic, latest-value ones with capacities 16, 1 and 2
      apply_settings(5'd0, 5'd16, 5'd1, 5'd2, 4'b1110);
      random_phase(100, 55, 35, 2'd1, 1'b0);
      // equal limits summing to the depth: full queue still drops oldest
      apply_settings(5'd4, 5'd4, 5'd4, 5'd4, 4'b1111);
      random_phase(60, 75, 15, 2'd0, 1'b0);
      for (int t = 0; t < 4; t++)
         caps[t] = ($urandom_range(7) == 0) ? 5'd31 : 5'($urandom_range(6));
      apply_settings(caps[0], caps[1], caps[2], caps[3], 4'($urandom_range(15)));
      random_phase(60, 55, 35, 2'($urandom_range(3)), 1'b0);
   endtask

   // Stop without discard keeps entries, closes input; stop with discard drops them
   task automatic test_stop_sequence();
      apply_settings(5'd31, 5'd31, 5'd31, 5'd31, 4'b1111);
      issue(OP_FLUSH, 2'd0, 4'd0, 32'd0, 1'b0);
      issue(OP_PAUSE, 2'd0, 4'd0, 32'd0, 1'b1);
      for (int k = 0; k < 3; k++) issue(OP_ENQUEUE, 2'(k), 4'(k + 7), $urandom, 1'b0);
      issue(OP_STOP, 2'd0, 4'd0, 32'd0, 1'b0);
      issue(OP_ENQUEUE, 2'd2, 4'd9, $urandom, 1'b0);
      issue(OP_PAUSE, 2'd0, 4'd0, 32'd0, 1'b1);
      issue(OP_DEQUEUE, 2'd0, 4'd0, 32'd0, 1'b0);
      issue(OP_PAUSE, 2'd0, 4'd0, 32'd0, 1'b0);
      issue(OP_DEQUEUE, 2'd0, 4'd0, 32'd0, 1'b0);
      issue(OP_STOP, 2'd0, 4'd0, 32'd0, 1'b1);
      issue(OP_DEQUEUE, 2'd0, 4'd0, 32'd0, 1'b0);
   endtask

   task automatic test_after_stop();
      random_phase(30, 40, 40, 2'd1, 1'b1);
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      reset_shadow();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_answers();
      test_field_extremes();
      test_reliable_limit();
      test_latest_drop();
      test_random_mix();
      test_stop_sequence();
      test_after_stop();

      wait_quiet();
      if (mismatch_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pcbq_pkg.sv
hw/rtl/pcbq_cell.sv
hw/rtl/pcbq_csr.sv
hw/rtl/per_class_bounded_queue.sv
verif/per_class_bounded_queue_tb.sv
